>>> rtl/matrix_vector_multiply_defines.svh
// assertion macros shared by the matrix-vector multiply rtl
// depends on a clock named aclk and an active-low reset named aresetn in scope
`ifndef MATRIX_VECTOR_MULTIPLY_DEFINES_SVH
`define MATRIX_VECTOR_MULTIPLY_DEFINES_SVH

// same-cycle implication, off during reset
`define MVM_ASSERT_NOW(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (expr)) \
        else $error("mvm check failed");

// next-cycle implication, off during reset
`define MVM_ASSERT_NEXT(label, cond, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (expr)) \
        else $error("mvm check failed");

`endif

>>> rtl/mvm_pkg.sv
// types and constants for the matrix-vector multiply block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mvm_pkg;

    localparam int DATA_W    = 32;
    localparam int VIDX_W    = 10;
    localparam int ROW_IDX_W = 10;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;

    // item modes
    localparam logic MODE_VECTOR = 1'b0;
    localparam logic MODE_MATRIX = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLS_IN_USE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_IN_USE = 1'b1;

    // per-item control carried down the pipeline
    typedef struct packed {
        logic                 valid;
        logic                 row_end;
        logic                 last_row;
        logic [ROW_IDX_W-1:0] row_index;
    } stage_tag_t;

endpackage

`default_nettype wire

>>> rtl/mvm_ram.sv
// generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module mvm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/matrix_vector_multiply.sv
// matrix-vector multiply top level: y = A * x on signed 32-bit integers
// depends on mvm_pkg, mvm_ram and matrix_vector_multiply_defines.svh
`timescale 1ns / 1ps
`default_nettype none

// Takes one item per clock while s_ready is high, via the vector store read
// plus one multiply and one accumulate stage. A vector item (mode 0) writes
// element_value into the vector store at vector_index; indexes at or above
// MAX_COLS are dropped. A matrix item (mode 1) is multiplied by the stored
// vector element at the running column and added into the row accumulator;
// the item that closes a row yields one result (row index, wrapped 32-bit
// dot product, last-row flag). m_valid rises once the closing matrix item
// has passed tag1 and tag2 into the output register. s_ready drops only
// while a finished row sits in the last stage and the output register is still
// held by m_ready low. Every vector entry used must be written before the
// matrix items that read it; unwritten entries read back as garbage. The
// store needs no clearing pass after reset. The user must write cols_in_use
// and rows_in_use only while idle; the block does not enforce this. 0 counts
// as 1 and values above MAX_COLS / MAX_ROWS saturate to the parameter.

`include "matrix_vector_multiply_defines.svh"

module matrix_vector_multiply #(
    parameter int MAX_COLS = 1024,
    parameter int MAX_ROWS = 1024
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,

    // configuration write channel
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [mvm_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [mvm_pkg::CFG_W-1:0]            cfg_data,

    // input item channel
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_mode,
    input  wire logic [mvm_pkg::VIDX_W-1:0]           s_vector_index,
    input  wire logic signed [mvm_pkg::DATA_W-1:0]    s_element_value,

    // result channel
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic [mvm_pkg::ROW_IDX_W-1:0]             m_row_index,
    output logic signed [mvm_pkg::DATA_W-1:0]         m_dot_product,
    output logic                                      m_last_row
);

    // counter widths follow the parameters
    localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    // compare widths: wide enough for the register and the parameter itself
    localparam int CEW = ($clog2(MAX_COLS + 1) > mvm_pkg::CFG_W) ?
                         $clog2(MAX_COLS + 1) : mvm_pkg::CFG_W;
    localparam int REW = ($clog2(MAX_ROWS + 1) > mvm_pkg::CFG_W) ?
                         $clog2(MAX_ROWS + 1) : mvm_pkg::CFG_W;

    // configuration registers
    logic [mvm_pkg::CFG_W-1:0] cols_cfg_reg;
    logic [mvm_pkg::CFG_W-1:0] rows_cfg_reg;

    // running position in the matrix
    logic [CW-1:0] col_cnt_reg, col_cnt_next;
    logic [RW-1:0] row_cnt_reg, row_cnt_next;

    // pipeline: stage 1 waits on the store read, stage 2 holds the product
    mvm_pkg::stage_tag_t              tag1_reg, tag2_reg;
    logic [mvm_pkg::DATA_W-1:0]       val1_reg;
    logic [mvm_pkg::DATA_W-1:0]       prod2_reg;
    logic [mvm_pkg::DATA_W-1:0]       acc_reg, acc_next;
    logic [mvm_pkg::DATA_W-1:0]       acc_sum;

    // output register
    logic                             m_valid_reg;
    logic [mvm_pkg::ROW_IDX_W-1:0]    m_row_index_reg;
    logic [mvm_pkg::DATA_W-1:0]       m_dot_reg;
    logic                             m_last_reg;

    // effective limits and handshake terms
    logic [CEW-1:0] ncols;
    logic [REW-1:0] nrows;
    logic           pipe_en;
    logic           in_fire;
    logic           mat_fire;
    logic           vec_fire;
    logic           vec_in_range;
    logic           row_end;
    logic           job_end;
    logic [mvm_pkg::DATA_W-1:0] x_rd_data;

    assign cfg_ready = 1'b1;

    // 0 counts as 1, oversize saturates to the parameter
    always_comb begin
        if (cols_cfg_reg == '0) begin
            ncols = CEW'(1);
        end else if (CEW'(cols_cfg_reg) > CEW'(MAX_COLS)) begin
            ncols = CEW'(MAX_COLS);
        end else begin
            ncols = CEW'(cols_cfg_reg);
        end
        if (rows_cfg_reg == '0) begin
            nrows = REW'(1);
        end else if (REW'(rows_cfg_reg) > REW'(MAX_ROWS)) begin
            nrows = REW'(MAX_ROWS);
        end else begin
            nrows = REW'(rows_cfg_reg);
        end
    end

    // the whole pipeline holds only when a finished row cannot leave
    assign pipe_en  = !(tag2_reg.valid && tag2_reg.row_end && m_valid_reg && !m_ready);
    assign s_ready  = pipe_en;
    assign in_fire  = s_valid && s_ready;
    assign mat_fire = in_fire && (s_mode == mvm_pkg::MODE_MATRIX);
    assign vec_fire = in_fire && (s_mode == mvm_pkg::MODE_VECTOR);
    assign vec_in_range = 32'(s_vector_index) < 32'(MAX_COLS);

    assign row_end = !((CEW'(col_cnt_reg) + CEW'(1)) < ncols);
    assign job_end = (REW'(row_cnt_reg) + REW'(1)) >= nrows;

    always_comb begin
        col_cnt_next = col_cnt_reg;
        row_cnt_next = row_cnt_reg;
        if (mat_fire) begin
            if (row_end) begin
                col_cnt_next = '0;
                row_cnt_next = job_end ? '0 : row_cnt_reg + RW'(1);
            end else begin
                col_cnt_next = col_cnt_reg + CW'(1);
            end
        end
    end

    // vector store: written by vector items, read at the running column
    mvm_ram #(
        .WIDTH (mvm_pkg::DATA_W),
        .DEPTH (MAX_COLS)
    ) u_vector_store (
        .aclk    (aclk),
        .wr_en   (vec_fire && vec_in_range),
        .wr_addr (CW'(s_vector_index)),
        .wr_data (s_element_value),
        .rd_en   (mat_fire),
        .rd_addr (col_cnt_reg),
        .rd_data (x_rd_data)
    );

    // accumulate in the last stage, clear after a row is handed out
    assign acc_sum = acc_reg + prod2_reg;

    always_comb begin
        acc_next = acc_reg;
        if (pipe_en && tag2_reg.valid) begin
            acc_next = tag2_reg.row_end ? '0 : acc_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_cfg_reg   <= mvm_pkg::CFG_W'(1);
            rows_cfg_reg   <= mvm_pkg::CFG_W'(1);
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            tag1_reg       <= '0;
            tag2_reg       <= '0;
            acc_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    mvm_pkg::REG_COLS_IN_USE: cols_cfg_reg <= cfg_data;
                    mvm_pkg::REG_ROWS_IN_USE: rows_cfg_reg <= cfg_data;
                    default: ;
                endcase
            end

            col_cnt_reg <= col_cnt_next;
            row_cnt_reg <= row_cnt_next;
            acc_reg     <= acc_next;

            if (pipe_en) begin
                tag1_reg.valid     <= mat_fire;
                tag1_reg.row_end   <= row_end;
                tag1_reg.last_row  <= job_end;
                tag1_reg.row_index <= mvm_pkg::ROW_IDX_W'(row_cnt_reg);
                tag2_reg           <= tag1_reg;
            end

            if (pipe_en && tag2_reg.valid && tag2_reg.row_end) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            val1_reg  <= s_element_value;
            prod2_reg <= val1_reg * x_rd_data;
        end
        if (pipe_en && tag2_reg.valid && tag2_reg.row_end) begin
            m_row_index_reg <= tag2_reg.row_index;
            m_dot_reg       <= acc_sum;
            m_last_reg      <= tag2_reg.last_row;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_row_index   = m_row_index_reg;
    assign m_dot_product = m_dot_reg;
    assign m_last_row    = m_last_reg;

    // a finished row blocked at the output must stall the input
    `MVM_ASSERT_NOW(a_stall_on_blocked_row, tag2_reg.valid && tag2_reg.row_end && m_valid_reg && !m_ready, !s_ready)
    // vector items never move the column counter
    `MVM_ASSERT_NEXT(a_vector_keeps_column, vec_fire, $stable(col_cnt_reg))
    // accumulator starts from zero after each row
    `MVM_ASSERT_NEXT(a_acc_cleared, pipe_en && tag2_reg.valid && tag2_reg.row_end, acc_reg == '0)
    // no matrix item is lost between stages
    `MVM_ASSERT_NEXT(a_stage_advance, pipe_en && tag1_reg.valid, tag2_reg.valid)

endmodule

`default_nettype wire
